FILE: rtl/fit_policy_block_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core_defines.svh
// Assertion macros used by the allocator RTL (fpba_back).
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Checked only out of reset.
`define FPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FPBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Types and constants of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Command field
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Classified operations
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_LOAD_BAD = 2'd1;
  localparam logic [1:0] OP_ALLOC    = 2'd2;

  // Fit policy codes (anything else acts as first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIT_POLICY    = 2'd0;
  localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd1;

  typedef struct packed {
    logic [1:0]           op;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
    logic                 eob;
  } q_entry_t;

  typedef struct packed {
    logic [1:0] fit_policy;
    logic [4:0] blocks_in_use;
  } cfg_t;

endpackage

FILE: rtl/fpba_front.sv
// ----------------------------------------------------------------------------
// fpba_front
// Accepts input transfers and classifies them into queue entries.
// ----------------------------------------------------------------------------
module fpba_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [3:0]           in_block_index,
  input  logic [15:0]          in_size_value,
  input  logic                 in_end_of_batch,
  input  logic                 q_full,
  output logic                 q_push,
  output fpba_pkg::q_entry_t   q_wdata
);
  import fpba_pkg::*;

  logic load_ok;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Loads beyond the table answer with no grant
  assign load_ok = (int'(in_block_index) < NUM_BLOCKS);

  always_comb begin
    q_wdata.idx  = IDX_W'(in_block_index);
    q_wdata.size = SIZE_BITS'(in_size_value);
    q_wdata.eob  = in_end_of_batch;
    if (in_command == CMD_ALLOC) begin
      q_wdata.op = OP_ALLOC;
    end else if (load_ok) begin
      q_wdata.op = OP_LOAD;
    end else begin
      q_wdata.op = OP_LOAD_BAD;
    end
  end

endmodule

FILE: rtl/fpba_queue.sv
// ----------------------------------------------------------------------------
// fpba_queue
// Short command FIFO decoupling the front from the allocation engine.
// ----------------------------------------------------------------------------
module fpba_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fpba_pkg::q_entry_t  wdata,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output fpba_pkg::q_entry_t  rdata
);
  import fpba_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/fpba_back.sv
// ----------------------------------------------------------------------------
// fpba_back
// Block table, sequential fit scan and result register.
// ----------------------------------------------------------------------------
`include "fit_policy_block_allocator_core_defines.svh"

module fpba_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fpba_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  fpba_pkg::q_entry_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_granted,
  output logic [3:0]          out_chosen_block,
  output logic [15:0]         out_remaining_after,
  output logic                out_batch_end
);
  import fpba_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [SIZE_BITS-1:0] tbl_r [NUM_BLOCKS];

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic                 is_load_r, is_load_nxt;
  logic                 eob_r, eob_nxt;

  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [3:0]           out_chosen_r;
  logic [15:0]          out_remain_r;
  logic                 out_eob_r;

  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     cnt_inc;
  logic [SIZE_BITS-1:0] scan_val;
  logic                 fits, take, first_only, pol_best, pol_worst;
  logic                 out_free, commit;
  logic [SIZE_BITS-1:0] wr_val;

  assign pol_best   = (cfg.fit_policy == POL_BEST);
  assign pol_worst  = (cfg.fit_policy == POL_WORST);
  assign first_only = !pol_best && !pol_worst;

  assign lim = (int'(cfg.blocks_in_use) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                       : CNT_W'(cfg.blocks_in_use);

  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign scan_val = tbl_r[cnt_r[IDX_W-1:0]];
  assign fits     = (scan_val >= req_r);
  assign take     = fits && (!found_r || (pol_best && scan_val < best_r) ||
                             (pol_worst && scan_val > best_r));

  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_FINISH) && out_free;
  assign wr_val   = is_load_r ? req_r : best_r - req_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    limit_nxt   = limit_r;
    found_nxt   = found_r;
    pick_nxt    = pick_r;
    best_nxt    = best_r;
    req_nxt     = req_r;
    is_load_nxt = is_load_r;
    eob_nxt     = eob_r;
    q_pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          req_nxt     = q_rdata.size;
          eob_nxt     = q_rdata.eob;
          is_load_nxt = (q_rdata.op != OP_ALLOC);
          found_nxt   = (q_rdata.op == OP_LOAD);
          pick_nxt    = (q_rdata.op == OP_ALLOC) ? '0 : q_rdata.idx;
          cnt_nxt     = '0;
          limit_nxt   = lim;
          if (q_rdata.op == OP_ALLOC && lim != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_inc;
        if (take) begin
          found_nxt = 1'b1;
          pick_nxt  = cnt_r[IDX_W-1:0];
          best_nxt  = scan_val;
        end
        // first fit stops at the first hit
        if (cnt_inc == limit_r || (fits && !found_r && first_only)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        tbl_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (commit && found_r) begin
        tbl_r[pick_r] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    limit_r   <= limit_nxt;
    found_r   <= found_nxt;
    pick_r    <= pick_nxt;
    best_r    <= best_nxt;
    req_r     <= req_nxt;
    is_load_r <= is_load_nxt;
    eob_r     <= eob_nxt;
    if (commit) begin
      out_granted_r <= found_r;
      out_chosen_r  <= found_r ? 4'(pick_r) : 4'd0;
      out_remain_r  <= found_r ? 16'(wr_val) : 16'd0;
      out_eob_r     <= eob_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted         = out_granted_r;
  assign out_chosen_block    = out_chosen_r;
  assign out_remaining_after = out_remain_r;
  assign out_batch_end       = out_eob_r;

  `FPBA_ASSERT(a_scan_in_range, (state_r == ST_SCAN) |-> (cnt_r < limit_r), "scan past limit")
  `FPBA_ASSERT(a_pop_when_idle, q_pop |-> (state_r == ST_IDLE), "queue popped while busy")
  `FPBA_ASSERT(a_commit_shows, commit |=> out_valid_r, "committed result not presented")
  `FPBA_ASSERT(a_hit_fits, (state_r == ST_SCAN && found_r && !is_load_r) |-> (best_r >= req_r), "held candidate does not fit")
  `FPBA_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset did not clear engine")

endmodule

FILE: rtl/fit_policy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Table of block sizes with first/best/worst fit allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): command 0 loads in_size_value into
//   block in_block_index, command 1 allocates in_size_value from the table.
//   Result channel (out_valid/out_stall): one transfer per input, giving the
//   grant flag, the chosen block and its remaining size, and the batch mark.
//   Config port (cfg_valid/cfg_ready, always ready): index 0 fit policy,
//   index 1 blocks scanned by allocate. Write only while the block is idle.
//   Order: an input waits in the command queue, is popped in the idle state,
//   scans N blocks for an allocate (N = min of blocks_in_use and 16, less
//   when first fit hits early), one table entry per cycle, then is written
//   to the output register. The engine holds one command at a time.
//   A 2-entry command queue lets input transfers continue during a scan.
//   Reset clears the table to zero, policy to first fit, scan count to 16.
//   A stalled result holds in the output register; the engine finishes its
//   current item and waits, and the queue then fills and stalls the input.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [3:0]  in_block_index,
  input  logic [15:0] in_size_value,
  input  logic        in_end_of_batch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_granted,
  output logic [3:0]  out_chosen_block,
  output logic [15:0] out_remaining_after,
  output logic        out_batch_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import fpba_pkg::*;

  cfg_t     cfg_r;
  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fit_policy    <= POL_FIRST;
      cfg_r.blocks_in_use <= 5'(NUM_BLOCKS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIT_POLICY:    cfg_r.fit_policy    <= cfg_data[1:0];
        CFG_BLOCKS_IN_USE: cfg_r.blocks_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  fpba_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_block_index  (in_block_index),
    .in_size_value   (in_size_value),
    .in_end_of_batch (in_end_of_batch),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  fpba_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  fpba_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_valid             (q_valid),
    .q_rdata             (q_rdata),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted         (out_granted),
    .out_chosen_block    (out_chosen_block),
    .out_remaining_after (out_remaining_after),
    .out_batch_end       (out_batch_end)
  );

endmodule
